/* hdl/assert_macros.svh */
// Assertion shorthands used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CHK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define CHK_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

/* hdl/pes_pkg.sv */
package pes_pkg;

    localparam int COUNT_W         = 9;
    // Only header offsets 0 to 18 are ever read back.
    localparam int STORE_BYTES     = 19;
    localparam int STORE_IDX_W     = $clog2(STORE_BYTES);
    localparam int MAX_STUFFED_LEN = 23;
    localparam int STAMP_BYTES     = 10;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_HIGH = 1'b1;

    localparam logic [7:0] ID_LOW_RESET  = 8'hE0;
    localparam logic [7:0] ID_HIGH_RESET = 8'hEF;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_ID   = 2'd1;
    localparam logic [1:0] ERR_STUFFING = 2'd2;

    typedef struct packed {
        logic                         payload;
        logic [7:0]                   data;
        logic                         tag;
        logic                         dts_sep;
        logic [1:0]                   err;
        logic [STAMP_BYTES-1:0][7:0]  stamp;
    } res_t;

    // Pack five timestamp bytes, keeping the low 32 bits of the 33-bit value.
    function automatic logic [31:0] stamp32(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c,
        input logic [7:0] d,
        input logic [7:0] e
    );
        return {a[2:1], b, c[7:1], d, e[7:1]};
    endfunction

endpackage

/* hdl/pes_front.sv */
module pes_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pes_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data,
    input  logic                               take,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_unit_start,
    output logic                               push,
    output pes_pkg::res_t                      push_item
);

    localparam int CW = pes_pkg::COUNT_W;
    localparam int SB = pes_pkg::STORE_BYTES;

    typedef enum logic [1:0] {MODE_SKIP, MODE_HEADER, MODE_DATA} mode_t;
    typedef enum logic [2:0] {
        PH_PREFIX, PH_KIND, PH_M2LEN, PH_M2BODY, PH_STUFF, PH_STD, PH_STAMP
    } phase_t;

    mode_t          mode_reg, mode_next, cur_mode;
    phase_t         phase_reg, phase_next, cur_phase;
    logic [CW-1:0]  count_reg, count_next, cur_count;
    logic [CW-1:0]  target_reg, target_next, cur_target;
    logic [CW-1:0]  off_reg, off_next;
    logic [CW-1:0]  cnt_inc, wr_addr;
    logic [7:0]     id_low_reg, id_high_reg;
    logic [7:0]     store_reg [SB];
    logic [7:0]     store_next [SB];
    logic [7:0]     cur_store [SB];
    logic [7:0]     store_wr [SB];
    logic           check_std, check_marker, done, tag;
    logic [1:0]     err;

    always_comb begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        target_next  = target_reg;
        off_next     = off_reg;
        store_next   = store_reg;
        cur_mode     = mode_reg;
        cur_phase    = phase_reg;
        cur_count    = count_reg;
        cur_target   = target_reg;
        cur_store    = store_reg;
        store_wr     = store_reg;
        cnt_inc      = count_reg + CW'(1);
        wr_addr      = count_reg;
        check_std    = 1'b0;
        check_marker = 1'b0;
        done         = 1'b0;
        tag          = 1'b0;
        err          = pes_pkg::ERR_NONE;
        push         = 1'b0;
        push_item    = '0;

        if (take) begin
            // A unit start restarts header collection from any mode.
            if (s_unit_start) begin
                cur_mode   = MODE_HEADER;
                cur_phase  = PH_PREFIX;
                cur_count  = '0;
                cur_target = CW'(4);
                cur_store  = '{default: 8'h00};
            end
            mode_next   = cur_mode;
            phase_next  = cur_phase;
            count_next  = cur_count;
            target_next = cur_target;
            store_next  = cur_store;
            store_wr    = cur_store;

            unique case (cur_mode)
                MODE_DATA: begin
                    push              = 1'b1;
                    push_item.payload = 1'b1;
                    push_item.data    = s_data_byte;
                end
                MODE_HEADER: begin
                    cnt_inc = cur_count + CW'(1);
                    wr_addr = (cur_phase == PH_STAMP) ? cur_count - off_reg : cur_count;
                    if (wr_addr < CW'(SB)) begin
                        store_wr[wr_addr[pes_pkg::STORE_IDX_W-1:0]] = s_data_byte;
                    end
                    store_next = store_wr;
                    count_next = cnt_inc;

                    if (cnt_inc == cur_target) begin
                        unique case (cur_phase)
                            PH_PREFIX: begin
                                if (store_wr[0] != 8'h00 || store_wr[1] != 8'h00 ||
                                    store_wr[2] != 8'h01) begin
                                    mode_next = MODE_SKIP;
                                end else if (s_data_byte < id_low_reg ||
                                             s_data_byte > id_high_reg) begin
                                    mode_next = MODE_SKIP;
                                    err       = pes_pkg::ERR_BAD_ID;
                                end else begin
                                    target_next = CW'(7);
                                    phase_next  = PH_KIND;
                                end
                            end
                            PH_KIND: begin
                                if (s_data_byte[7:6] == 2'b10) begin
                                    target_next = CW'(9);
                                    phase_next  = PH_M2LEN;
                                end else if (s_data_byte == 8'hFF) begin
                                    target_next = CW'(8);
                                    phase_next  = PH_STUFF;
                                end else begin
                                    check_std = 1'b1;
                                end
                            end
                            PH_M2LEN: begin
                                target_next = CW'(9) + CW'(s_data_byte);
                                if (s_data_byte == 8'h00) begin
                                    done = 1'b1;
                                end else begin
                                    phase_next = PH_M2BODY;
                                end
                            end
                            PH_M2BODY: done = 1'b1;
                            PH_STUFF: begin
                                // Cut the stuffing run once the header grows too long.
                                if (cnt_inc > CW'(pes_pkg::MAX_STUFFED_LEN)) begin
                                    err       = pes_pkg::ERR_STUFFING;
                                    check_std = 1'b1;
                                end else if (s_data_byte == 8'hFF) begin
                                    target_next = cur_target + CW'(1);
                                end else begin
                                    check_std = 1'b1;
                                end
                            end
                            PH_STD: check_marker = 1'b1;
                            default: done = 1'b1;
                        endcase

                        if (check_std) begin
                            if (s_data_byte[7:6] == 2'b01) begin
                                target_next = cnt_inc + CW'(2);
                                phase_next  = PH_STD;
                            end else begin
                                check_marker = 1'b1;
                            end
                        end

                        // Rebase the store so the marker byte lands at offset zero.
                        if (check_marker) begin
                            off_next      = cnt_inc - CW'(1);
                            store_next[0] = s_data_byte;
                            if (s_data_byte[7:4] == 4'h2) begin
                                target_next = cnt_inc + CW'(4);
                                phase_next  = PH_STAMP;
                            end else if (s_data_byte[7:4] == 4'h3) begin
                                target_next = cnt_inc + CW'(9);
                                phase_next  = PH_STAMP;
                            end else begin
                                done = 1'b1;
                            end
                        end

                        if (done) begin
                            mode_next = MODE_DATA;
                            if ((cur_phase == PH_M2LEN || cur_phase == PH_M2BODY) &&
                                store_wr[7][7]) begin
                                tag               = 1'b1;
                                push_item.dts_sep = store_wr[7][6];
                                for (int i = 0; i < pes_pkg::STAMP_BYTES; i++) begin
                                    push_item.stamp[i] = store_wr[9 + i];
                                end
                            end else if (cur_phase == PH_STAMP) begin
                                tag               = 1'b1;
                                push_item.dts_sep = (store_wr[0][7:4] == 4'h3);
                                for (int i = 0; i < pes_pkg::STAMP_BYTES; i++) begin
                                    push_item.stamp[i] = store_wr[i];
                                end
                            end
                        end

                        if (tag || err != pes_pkg::ERR_NONE) begin
                            push = 1'b1;
                        end
                        push_item.tag = tag;
                        push_item.err = err;
                        if (!tag) begin
                            push_item.dts_sep = 1'b0;
                            push_item.stamp   = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_SKIP;
            phase_reg   <= PH_PREFIX;
            count_reg   <= '0;
            target_reg  <= CW'(4);
            off_reg     <= '0;
            id_low_reg  <= pes_pkg::ID_LOW_RESET;
            id_high_reg <= pes_pkg::ID_HIGH_RESET;
        end else begin
            mode_reg   <= mode_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            target_reg <= target_next;
            off_reg    <= off_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    pes_pkg::REG_ID_LOW:  id_low_reg  <= cfg_data;
                    pes_pkg::REG_ID_HIGH: id_high_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        store_reg <= store_next;
    end

endmodule

/* hdl/pes_queue.sv */
module pes_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pes_pkg::res_t push_item,
    output logic          full,
    input  logic          pop,
    output pes_pkg::res_t pop_item,
    output logic          empty
);

    localparam int DEPTH = pes_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pes_pkg::res_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/pes_back.sv */
module pes_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  pes_pkg::res_t q_item,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_payload_valid,
    output logic [7:0]    m_out_byte,
    output logic          m_tag_valid,
    output logic [31:0]   m_pts_value,
    output logic [31:0]   m_dts_value,
    output logic [1:0]    m_error_code
);

    logic        valid_reg;
    logic        payload_reg;
    logic [7:0]  byte_reg;
    logic        tag_reg;
    logic [31:0] pts_reg, dts_reg, pts_next, dts_next;
    logic [1:0]  err_reg;

    assign q_pop = !q_empty && (!valid_reg || m_ready);

    always_comb begin
        pts_next = '0;
        dts_next = '0;
        if (q_item.tag) begin
            pts_next = pes_pkg::stamp32(q_item.stamp[0], q_item.stamp[1], q_item.stamp[2],
                                        q_item.stamp[3], q_item.stamp[4]);
            dts_next = q_item.dts_sep
                ? pes_pkg::stamp32(q_item.stamp[5], q_item.stamp[6], q_item.stamp[7],
                                   q_item.stamp[8], q_item.stamp[9])
                : pts_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            payload_reg <= q_item.payload;
            byte_reg    <= q_item.data;
            tag_reg     <= q_item.tag;
            pts_reg     <= pts_next;
            dts_reg     <= dts_next;
            err_reg     <= q_item.err;
        end
    end

    assign m_valid         = valid_reg;
    assign m_payload_valid = payload_reg;
    assign m_out_byte      = byte_reg;
    assign m_tag_valid     = tag_reg;
    assign m_pts_value     = pts_reg;
    assign m_dts_value     = dts_reg;
    assign m_error_code    = err_reg;

endmodule

/* hdl/pes_header_parser_core.sv */
// PES header parser: takes one transport payload byte per cycle while the queue is not
// full, with a unit-start flag; the parse state (mode, header count, target, phase) is
// updated as each byte is taken, which sets that rate. A result reaches the m_ side
// through registers: the parser feeds a two-entry queue, and an output stage
// registers it and packs the PTS/DTS tag. Payload bytes come out one result per byte;
// a completed header with a timestamp gives one tag result; a bad stream id or cut
// stuffing gives an error result. Write the stream id range only while idle.
module pes_header_parser_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pes_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_unit_start,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_payload_valid,
    output logic [7:0]                       m_out_byte,
    output logic                             m_tag_valid,
    output logic [31:0]                      m_pts_value,
    output logic [31:0]                      m_dts_value,
    output logic [1:0]                       m_error_code
);

    logic          take;
    logic          push, q_full, q_pop, q_empty;
    pes_pkg::res_t push_item, q_item;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    pes_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .s_data_byte  (s_data_byte),
        .s_unit_start (s_unit_start),
        .push         (push),
        .push_item    (push_item)
    );

    pes_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    pes_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_valid (m_payload_valid),
        .m_out_byte      (m_out_byte),
        .m_tag_valid     (m_tag_valid),
        .m_pts_value     (m_pts_value),
        .m_dts_value     (m_dts_value),
        .m_error_code    (m_error_code)
    );

endmodule

/* hdl/pes_checker.sv */
`include "assert_macros.svh"

module pes_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_payload_valid,
    input logic [7:0]  m_out_byte,
    input logic        m_tag_valid,
    input logic [31:0] m_pts_value,
    input logic [31:0] m_dts_value,
    input logic [1:0]  m_error_code
);

    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_pts_value) && $stable(m_error_code), "result changed while stalled")
    `CHK_ASSERT(a_payload_alone, aclk, aresetn, m_valid && m_payload_valid |-> !m_tag_valid && m_error_code == pes_pkg::ERR_NONE, "payload transfer mixed with tag or error")
    `CHK_NEVER(a_no_empty_result, aclk, aresetn, m_valid && !m_payload_valid && !m_tag_valid && m_error_code == pes_pkg::ERR_NONE, "result carries nothing")
    `CHK_ASSERT(a_untagged_zero, aclk, aresetn, m_valid && !m_tag_valid |-> m_pts_value == 32'd0 && m_dts_value == 32'd0, "stamp set without tag")

endmodule

bind pes_header_parser_core pes_checker u_pes_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_payload_valid (m_payload_valid),
    .m_out_byte      (m_out_byte),
    .m_tag_valid     (m_tag_valid),
    .m_pts_value     (m_pts_value),
    .m_dts_value     (m_dts_value),
    .m_error_code    (m_error_code)
);
